// ===== design/ppc_pkg.sv =====
// Shared types, constants and helpers for the polygon plane clipper.
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int NCOMP    = 5;
  localparam int CW       = 32;
  localparam int MUL_W    = CW + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int T_BITS   = 30;
  localparam int QW       = T_BITS + 1;
  localparam int BL       = 31;
  localparam int DC_W     = $clog2(T_BITS + 1);
  localparam int LERP_W   = CW + 6;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [1:0] REG_NX  = 2'd0;
  localparam logic [1:0] REG_NY  = 2'd1;
  localparam logic [1:0] REG_NZ  = 2'd2;
  localparam logic [1:0] REG_OFS = 2'd3;

  localparam logic [CW-1:0] NX_RST  = 32'h0000_0000;
  localparam logic [CW-1:0] NY_RST  = 32'h0000_0000;
  localparam logic [CW-1:0] NZ_RST  = 32'h0001_0000;
  localparam logic [CW-1:0] OFS_RST = 32'h0000_0000;

  localparam logic [2:0] C_X = 3'd0;
  localparam logic [2:0] C_Y = 3'd1;
  localparam logic [2:0] C_Z = 3'd2;
  localparam logic [2:0] C_U = 3'd3;
  localparam logic [2:0] C_V = 3'd4;

  typedef logic [NCOMP-1:0][CW-1:0] ppc_vtx_t;

  typedef struct packed {
    ppc_vtx_t vtx;
    logic     wr;
    logic     fin;
    logic     ovf;
  } ppc_job_t;

  typedef struct packed {
    ppc_vtx_t vtx;
    logic     empty;
    logic     ovf;
    logic     last;
  } ppc_res_t;

  typedef struct packed {
    logic          en;
    logic [1:0]    idx;
    logic [CW-1:0] data;
  } ppc_cfg_t;

  function automatic logic [CW-1:0] sat32(input logic signed [LERP_W-1:0] v);
    logic signed [LERP_W-1:0] smax;
    logic signed [LERP_W-1:0] smin;
    logic [CW-1:0] r;
    smax = signed'({{(LERP_W-CW){1'b0}}, 32'h7fff_ffff});
    smin = signed'({{(LERP_W-CW){1'b1}}, 32'h8000_0000});
    if (v > smax) begin
      r = 32'h7fff_ffff;
    end else if (v < smin) begin
      r = 32'h8000_0000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ppc_fifo.sv =====
// Small register queue with full and empty flags.
`timescale 1ns / 1ps
module ppc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

// ===== design/ppc_front.sv =====
// Vertex intake: counts vertices, flags drops past capacity and queues jobs.
`timescale 1ns / 1ps
module ppc_front import ppc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  ppc_vtx_t vtx,
  input  logic     final_vertex,
  output logic     q_push,
  output ppc_job_t q_job,
  input  logic     q_full
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             drop_r;
  logic             wr;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign wr     = (cnt_r != CNT_W'(MAX_VERTICES));

  always_comb begin
    q_job.vtx = vtx;
    q_job.wr  = wr;
    q_job.fin = final_vertex;
    q_job.ovf = drop_r || !wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (q_push) begin
      if (final_vertex) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end else begin
        cnt_r  <= cnt_r + CNT_W'(wr);
        drop_r <= drop_r || !wr;
      end
    end
  end

endmodule

// ===== design/ppc_back.sv =====
// Clip engine: vertex store, plane distances, crossing divide and interpolation.
`timescale 1ns / 1ps
module ppc_back import ppc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ppc_cfg_t cfg,
  input  ppc_job_t job,
  input  logic     job_empty,
  output logic     job_pop,
  output logic     res_push,
  output ppc_res_t res,
  input  logic     res_full
);

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = PROD_W - FRAC_BITS;
  localparam int AW    = DW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_DMUL  = 4'd3;
  localparam logic [3:0] S_DACC  = 4'd4;
  localparam logic [3:0] S_EDGE  = 4'd5;
  localparam logic [3:0] S_EMITP = 4'd6;
  localparam logic [3:0] S_XCHK  = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_LMUL  = 4'd10;
  localparam logic [3:0] S_LACC  = 4'd11;
  localparam logic [3:0] S_EMITX = 4'd12;
  localparam logic [3:0] S_NEXT  = 4'd13;
  localparam logic [3:0] S_FLUSH = 4'd14;

  logic [3:0]               st_r;
  logic [CW-1:0]            nx_r, ny_r, nz_r, ofs_r;
  ppc_vtx_t                 mem [MAX_VERTICES];
  ppc_vtx_t                 rd_r, cur_r, prev_r, xv_r, hold_r;
  logic                     hold_v_r;
  logic [CNT_W-1:0]         n_r, nc_r, k_r;
  logic                     ovf_r;
  logic [2:0]               ci_r;
  logic signed [DW-1:0]     acc_r, dprev_r;
  logic signed [PROD_W-1:0] p_r;
  logic [AW-1:0]            a_r, b_r;
  logic [QW-1:0]            q_r;
  logic [BL-1:0]            rm_r;
  logic [DC_W-1:0]          dc_r;

  logic [IDX_W-1:0]         rd_addr;
  logic [CW-1:0]            nsel;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod, psh, lsh;
  logic signed [AW-1:0]     dd;
  logic [AW-1:0]            a_new, b_new;
  logic [BL:0]              r2, bb;
  logic                     ge;
  logic signed [LERP_W-1:0] lsum;
  logic                     emit_st, emit_go;

  assign job_pop = (st_r == S_IDLE) && !job_empty;
  assign rd_addr = (k_r == nc_r) ? '0 : k_r[IDX_W-1:0];
  assign emit_st = (st_r == S_EMITP) || (st_r == S_EMITX);
  assign emit_go = !hold_v_r || !res_full;

  always_comb begin
    nsel = (ci_r == C_X) ? nx_r : ((ci_r == C_Y) ? ny_r : nz_r);
    if (st_r == S_LMUL) begin
      ma = signed'({cur_r[ci_r][CW-1], cur_r[ci_r]}) -
           signed'({prev_r[ci_r][CW-1], prev_r[ci_r]});
      mb = signed'({{(MUL_W-QW){1'b0}}, q_r});
    end else begin
      ma = signed'({nsel[CW-1], nsel});
      mb = signed'({cur_r[ci_r][CW-1], cur_r[ci_r]});
    end
  end

  assign prod  = ma * mb;
  assign psh   = p_r >>> FRAC_BITS;
  assign lsh   = p_r >>> T_BITS;
  assign lsum  = signed'({{(LERP_W-CW){prev_r[ci_r][CW-1]}}, prev_r[ci_r]}) +
                 signed'(lsh[LERP_W-1:0]);
  assign dd    = signed'({dprev_r[DW-1], dprev_r}) - signed'({acc_r[DW-1], acc_r});
  assign a_new = dprev_r[DW-1] ? AW'(-{dprev_r[DW-1], dprev_r})
                               : AW'({dprev_r[DW-1], dprev_r});
  assign b_new = dd[AW-1] ? AW'(-dd) : AW'(dd);
  assign ge    = (a_r[BL-1:0] >= b_r[BL-1:0]);
  assign r2    = {rm_r, 1'b0};
  assign bb    = {1'b0, b_r[BL-1:0]};

  always_comb begin
    res.ovf  = ovf_r;
    res.vtx  = hold_r;
    res.empty = 1'b0;
    res.last = 1'b0;
    res_push = 1'b0;
    if (emit_st) begin
      res_push = hold_v_r && !res_full;
    end else if (st_r == S_FLUSH) begin
      res_push = !res_full;
      res.last = 1'b1;
      if (!hold_v_r) begin
        res.vtx   = '0;
        res.empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop && job.wr) begin
      mem[n_r[IDX_W-1:0]] <= job.vtx;
    end
    if (st_r == S_READ) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= NX_RST;
      ny_r  <= NY_RST;
      nz_r  <= NZ_RST;
      ofs_r <= OFS_RST;
    end else if (cfg.en) begin
      unique case (cfg.idx)
        REG_NX:  nx_r  <= cfg.data;
        REG_NY:  ny_r  <= cfg.data;
        REG_NZ:  nz_r  <= cfg.data;
        REG_OFS: ofs_r <= cfg.data;
        default: nx_r  <= nx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      n_r      <= '0;
      nc_r     <= '0;
      k_r      <= '0;
      ovf_r    <= 1'b0;
      ci_r     <= '0;
      dc_r     <= '0;
      hold_v_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (job_pop) begin
            if (job.fin) begin
              nc_r  <= n_r + CNT_W'(job.wr);
              n_r   <= '0;
              ovf_r <= job.ovf;
              k_r   <= '0;
              st_r  <= S_READ;
            end else begin
              n_r <= n_r + CNT_W'(job.wr);
            end
          end
        end
        S_READ: st_r <= S_LOAD;
        S_LOAD: begin
          cur_r <= rd_r;
          acc_r <= -signed'({{(DW-CW){ofs_r[CW-1]}}, ofs_r});
          ci_r  <= '0;
          st_r  <= S_DMUL;
        end
        S_DMUL: begin
          p_r  <= prod;
          st_r <= S_DACC;
        end
        S_DACC: begin
          acc_r <= acc_r + signed'(psh[DW-1:0]);
          if (ci_r == C_Z) begin
            st_r <= S_EDGE;
          end else begin
            ci_r <= ci_r + 3'd1;
            st_r <= S_DMUL;
          end
        end
        S_EDGE: begin
          if (k_r == '0) begin
            prev_r  <= cur_r;
            dprev_r <= acc_r;
            k_r     <= CNT_W'(1);
            st_r    <= S_READ;
          end else begin
            st_r <= dprev_r[DW-1] ? S_EMITP : S_XCHK;
          end
        end
        S_EMITP: begin
          if (emit_go) begin
            hold_r   <= prev_r;
            hold_v_r <= 1'b1;
            st_r     <= S_XCHK;
          end
        end
        S_XCHK: begin
          if (dprev_r[DW-1] != acc_r[DW-1]) begin
            a_r  <= a_new;
            b_r  <= b_new;
            st_r <= S_NORM;
          end else begin
            st_r <= S_NEXT;
          end
        end
        S_NORM: begin
          if (|b_r[AW-1:BL]) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
          end else begin
            q_r  <= QW'(ge);
            rm_r <= ge ? (a_r[BL-1:0] - b_r[BL-1:0]) : a_r[BL-1:0];
            dc_r <= DC_W'(T_BITS);
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (r2 >= bb) begin
            rm_r <= BL'(r2 - bb);
            q_r  <= {q_r[QW-2:0], 1'b1};
          end else begin
            rm_r <= r2[BL-1:0];
            q_r  <= {q_r[QW-2:0], 1'b0};
          end
          dc_r <= dc_r - DC_W'(1);
          if (dc_r == DC_W'(1)) begin
            ci_r <= '0;
            st_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          p_r  <= prod;
          st_r <= S_LACC;
        end
        S_LACC: begin
          xv_r[ci_r] <= sat32(lsum);
          if (ci_r == C_V) begin
            st_r <= S_EMITX;
          end else begin
            ci_r <= ci_r + 3'd1;
            st_r <= S_LMUL;
          end
        end
        S_EMITX: begin
          if (emit_go) begin
            hold_r   <= xv_r;
            hold_v_r <= 1'b1;
            st_r     <= S_NEXT;
          end
        end
        S_NEXT: begin
          prev_r  <= cur_r;
          dprev_r <= acc_r;
          if (k_r == nc_r) begin
            st_r <= S_FLUSH;
          end else begin
            k_r  <= k_r + CNT_W'(1);
            st_r <= S_READ;
          end
        end
        S_FLUSH: begin
          if (!res_full) begin
            hold_v_r <= 1'b0;
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/polygon_plane_clipper.sv =====
// Top level of the single-plane polygon clipper.
// After the final vertex the clip walks n+1 vertex slots, the first vertex again to close the loop;
// each slot reads and loads a vertex and sums its plane distance, the inside start vertex of each
// edge is emitted, and each crossing is normalised, divided, interpolated and emitted, then flush.
// Throughput: one polygon at a time in the clip engine; emit and flush wait on a full 4-entry
// result queue, a 2-entry job queue decouples intake. Synchronous active-low reset.
`timescale 1ns / 1ps
module polygon_plane_clipper import ppc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [CW-1:0] in_pos_x,
  input  logic signed [CW-1:0] in_pos_y,
  input  logic signed [CW-1:0] in_pos_z,
  input  logic signed [CW-1:0] in_tex_u,
  input  logic signed [CW-1:0] in_tex_v,
  input  logic                 in_final_vertex,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic signed [CW-1:0] out_u,
  output logic signed [CW-1:0] out_v,
  output logic                 out_empty_result,
  output logic                 out_overflowed,
  output logic                 out_last_of_polygon,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  ppc_vtx_t in_vtx;
  ppc_job_t f_job, q_job;
  logic     f_push, q_full, q_empty, q_pop;
  ppc_res_t b_res, o_res;
  logic     b_push, o_full;
  ppc_cfg_t cfg;

  assign in_vtx    = {in_tex_v, in_tex_u, in_pos_z, in_pos_y, in_pos_x};
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.en   = cfg_valid;
    cfg.idx  = cfg_index;
    cfg.data = cfg_data;
  end

  ppc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .vtx(in_vtx),
    .final_vertex(in_final_vertex), .q_push(f_push), .q_job(f_job), .q_full(q_full)
  );

  ppc_fifo #(.WIDTH($bits(ppc_job_t)), .DEPTH(MID_DEPTH)) u_jobq (
    .clk(clk), .rst_n(rst_n), .push(f_push), .din(f_job), .full(q_full),
    .pop(q_pop), .dout(q_job), .empty(q_empty)
  );

  ppc_back #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .job(q_job), .job_empty(q_empty),
    .job_pop(q_pop), .res_push(b_push), .res(b_res), .res_full(o_full)
  );

  ppc_fifo #(.WIDTH($bits(ppc_res_t)), .DEPTH(OUT_DEPTH)) u_resq (
    .clk(clk), .rst_n(rst_n), .push(b_push), .din(b_res), .full(o_full),
    .pop(pop), .dout(o_res), .empty(empty)
  );

  assign out_x               = o_res.vtx[C_X];
  assign out_y               = o_res.vtx[C_Y];
  assign out_z               = o_res.vtx[C_Z];
  assign out_u               = o_res.vtx[C_U];
  assign out_v               = o_res.vtx[C_V];
  assign out_empty_result    = o_res.empty;
  assign out_overflowed      = o_res.ovf;
  assign out_last_of_polygon = o_res.last;

`ifndef ASSERT_OFF
  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_push && o_full)) else $error("result transfer into a full queue");
  a_job_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && q_full)) else $error("job transfer into a full queue");
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_empty_result) |-> (out_last_of_polygon && out_x == '0 && out_v == '0))
    else $error("empty marker malformed");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the single-plane polygon clipper: directed table, random polygons, scoreboard.
`timescale 1ns / 1ps
module tb import ppc_pkg::*; ();

  typedef struct packed {
    logic signed [31:0] x, y, z, u, v;
    logic               emp, ovf, last;
  } clip_vtx_t;

  typedef struct {
    logic signed [31:0] x, y, z, u, v;
    bit                 fin;
    bit                 typed_empty;
  } stim_row_t;

  localparam int NV        = 16;
  localparam int SETTLE    = 2500;
  localparam int WD_LIMIT  = 40000;

  logic clk = 1'b0;
  logic rst_n;
  logic push, full, pop, empty;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v;
  logic in_final_vertex;
  logic signed [31:0] out_x, out_y, out_z, out_u, out_v;
  logic out_empty_result, out_overflowed, out_last_of_polygon;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  always #2 clk = ~clk;

  polygon_plane_clipper DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_tex_u(in_tex_u), .in_tex_v(in_tex_v), .in_final_vertex(in_final_vertex),
    .empty(empty), .pop(pop),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_u(out_u), .out_v(out_v),
    .out_empty_result(out_empty_result), .out_overflowed(out_overflowed),
    .out_last_of_polygon(out_last_of_polygon),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clipper model state
  logic signed [31:0] plane_n [3];
  logic signed [31:0] plane_ofs;
  logic signed [31:0] held_vtx [NV][5];
  int                 held_count;
  bit                 held_drop;

  clip_vtx_t clipped_q [$];
  int  mismatches, n_items, n_polys, n_results, n_drops;
  bit  no_idle;
  int  quiet_cycles;

  function automatic longint plane_dist(int k);
    longint acc;
    acc = 0;
    for (int c = 0; c < 3; c++)
      acc += (longint'(plane_n[c]) * longint'(held_vtx[k][c])) >>> FRAC_BITS_DEF;
    return acc - longint'(plane_ofs);
  endfunction

  function automatic logic signed [31:0] lerp_sat(logic signed [31:0] c0,
                                                  logic signed [31:0] c1, longint t);
    longint r;
    r = longint'(c0) + (((longint'(c1) - longint'(c0)) * t) >>> T_BITS);
    if (r > 64'sd2147483647) return 32'h7fff_ffff;
    if (r < -64'sd2147483648) return 32'h8000_0000;
    return r[31:0];
  endfunction

  task automatic clip_vertex(logic signed [31:0] vx, vy, vz, vu, vv, bit fin,
                             bit keep);
    longint d [NV];
    longint unsigned a, b;
    longint t;
    int j, k;
    clip_vtx_t r;
    if (held_count < NV) begin
      held_vtx[held_count] = '{vx, vy, vz, vu, vv};
      held_count++;
    end else begin
      held_drop = 1'b1;
    end
    n_items++;
    if (!fin) return;
    n_polys++;
    if (held_drop) n_drops++;
    k = 0;
    for (int i = 0; i < held_count; i++) d[i] = plane_dist(i);
    for (int i = 0; i < held_count; i++) begin
      j = (i + 1 == held_count) ? 0 : i + 1;
      if (d[i] < 0) begin
        r = '{held_vtx[i][0], held_vtx[i][1], held_vtx[i][2], held_vtx[i][3],
              held_vtx[i][4], 1'b0, held_drop, 1'b0};
        if (keep) clipped_q.push_back(r);
        k++;
      end
      if ((d[i] < 0) != (d[j] < 0)) begin
        a = (d[i] < 0) ? -d[i] : d[i];
        b = (d[i] - d[j] < 0) ? d[j] - d[i] : d[i] - d[j];
        while (b >= 64'h8000_0000) begin
          a >>= 1;
          b >>= 1;
        end
        t = longint'((a << T_BITS) / b);
        r = '{lerp_sat(held_vtx[i][0], held_vtx[j][0], t),
              lerp_sat(held_vtx[i][1], held_vtx[j][1], t),
              lerp_sat(held_vtx[i][2], held_vtx[j][2], t),
              lerp_sat(held_vtx[i][3], held_vtx[j][3], t),
              lerp_sat(held_vtx[i][4], held_vtx[j][4], t), 1'b0, held_drop, 1'b0};
        if (keep) clipped_q.push_back(r);
        k++;
      end
    end
    if (keep) begin
      if (k == 0) clipped_q.push_back('{0, 0, 0, 0, 0, 1'b1, held_drop, 1'b1});
      else clipped_q[$].last = 1'b1;
    end
    held_count = 0;
    held_drop = 1'b0;
  endtask

  task automatic send_vertex(logic signed [31:0] vx, vy, vz, vu, vv, bit fin);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push <= 1'b1;
    in_pos_x <= vx;
    in_pos_y <= vy;
    in_pos_z <= vz;
    in_tex_u <= vu;
    in_tex_v <= vv;
    in_final_vertex <= fin;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    push <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NX:  plane_n[0] = val;
      REG_NY:  plane_n[1] = val;
      REG_NZ:  plane_n[2] = val;
      REG_OFS: plane_ofs = val;
    endcase
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000;
    endcase
  endfunction

  task automatic random_polygons(int items);
    int sent, nv;
    logic signed [31:0] c [5];
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: nv = $urandom_range(1, 2);
        1: nv = $urandom_range(15, 19);
        default: nv = $urandom_range(3, 7);
      endcase
      for (int i = 0; i < nv; i++) begin
        foreach (c[m]) c[m] = rand_coord();
        send_vertex(c[0], c[1], c[2], c[3], c[4], i == nv - 1);
        clip_vertex(c[0], c[1], c[2], c[3], c[4], i == nv - 1, 1'b1);
      end
      sent += nv;
    end
  endtask

  stim_row_t dir_rows [] = '{
    '{32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000, 32'sh0000_0000, 0, 0},
    '{32'sh0003_0000, 32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0},
    '{32'sh0002_0000, 32'sh0005_0000, -32'sh0000_0001, 32'sh0000_0000, 32'sh0001_0000, 1, 0},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 0, 1},
    '{32'sh0002_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 0, 1},
    '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1},
    '{32'sh0000_0000, 32'sh0000_0000, -32'sh0004_0000, 32'sh0000_0000, 32'sh0000_0000, 0, 0},
    '{32'sh0004_0000, 32'sh0000_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0000_0000, 0, 0},
    '{32'sh0000_0000, 32'sh0004_0000, 32'sh0002_0000, 32'sh0000_0000, 32'sh0001_0000, 1, 0},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0},
    '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0},
    '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0},
    '{32'sh1234_5678, 32'sh8765_4321, -32'sh0000_0001, 32'sh5555_aaaa, 32'shaaaa_5555, 1, 0},
    '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1, 1},
    '{32'sh0001_0000, 32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 0, 0},
    '{32'sh0002_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 0, 0},
    '{32'sh0003_0000, 32'sh0000_0000, -32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000, 0, 0},
    '{32'sh0004_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1, 0}
  };

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_NX;
    cfg_data = '0;
    {in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v} = '0;
    in_final_vertex = 1'b0;
    plane_n = '{NX_RST, NY_RST, NZ_RST};
    plane_ofs = OFS_RST;
    held_count = 0;
    held_drop = 1'b0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_vertex(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z, dir_rows[r].u, dir_rows[r].v,
                  dir_rows[r].fin);
      clip_vertex(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z, dir_rows[r].u, dir_rows[r].v,
                  dir_rows[r].fin, !dir_rows[r].typed_empty);
      if (dir_rows[r].typed_empty && dir_rows[r].fin)
        clipped_q.push_back('{0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1});
    end
    random_polygons(30);
    drain_and_settle();

    write_reg(REG_NX, 32'h0001_0000);
    write_reg(REG_NZ, 32'h0000_0000);
    write_reg(REG_OFS, 32'h0000_8000);
    random_polygons(50);
    drain_and_settle();

    write_reg(REG_NX, 32'h7fff_ffff);
    write_reg(REG_NY, 32'h8000_0000);
    write_reg(REG_NZ, 32'h0000_0000);
    write_reg(REG_OFS, 32'h8000_0000);
    random_polygons(40);
    drain_and_settle();

    write_reg(REG_NX, $urandom);
    write_reg(REG_NY, $urandom);
    write_reg(REG_NZ, $urandom);
    write_reg(REG_OFS, $urandom);
    random_polygons(40);
    drain_and_settle();

    write_reg(REG_NX, 32'h0001_0000);
    write_reg(REG_NY, 32'h0001_0000);
    write_reg(REG_NZ, 32'h8000_0000);
    write_reg(REG_OFS, 32'h7fff_ffff);
    no_idle = 1'b1;
    random_polygons(50);
    drain_and_settle();

    $display("Covered %0d vertices in %0d polygons (%0d with dropped vertices), %0d results",
             n_items, n_polys, n_drops, n_results);
    $display("over five plane settings including the register extremes.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  int stall_left = 0;
  always @(posedge clk) begin
    clip_vtx_t got, want;
    if (rst_n && pop && !empty) begin
      got = '{out_x, out_y, out_z, out_u, out_v, out_empty_result, out_overflowed,
              out_last_of_polygon};
      n_results++;
      if (clipped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        want = clipped_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.u !== want.u ||
            got.v !== want.v || got.emp !== want.emp || got.ovf !== want.ovf ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WD_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
